### rtl/ray_nearest_wall_hit_assert.svh
// Assertion macros for the ray/wall hit block.
// Included by the top level; needs nothing else.
`ifndef RAY_NEAREST_WALL_HIT_ASSERT_SVH
`define RAY_NEAREST_WALL_HIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RNWH_ASSERT(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define RNWH_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RNWH_ASSERT(name, clk, rst_n, cond)
`define RNWH_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rnwh_pkg.sv
// Shared constants and types for the ray/wall hit block.
// No dependencies.
`default_nettype none

package rnwh_pkg;

    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned RADIUS_BITS    = 16;
    localparam int unsigned CFG_ADDR_BITS  = 2;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RADIUS   = 2'd2;

    localparam logic OP_RAY  = 1'b0;
    localparam logic OP_WALL = 1'b1;

    // status of the intersection front end
    typedef struct packed {
        logic done;
        logic pass;
    } t_isect_stat;

    function automatic int unsigned cfg_data_bits(input int unsigned coord_bits);
        return (coord_bits > RADIUS_BITS) ? coord_bits : RADIUS_BITS;
    endfunction

endpackage

`default_nettype wire

### rtl/rnwh_if.sv
// Channel interfaces: item input, result output and register writes.
// Depends on rnwh_pkg.
`default_nettype none

interface rnwh_item_if import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] point_a_x;
    logic signed [COORD_BITS-1:0] point_a_y;
    logic signed [COORD_BITS-1:0] point_b_x;
    logic signed [COORD_BITS-1:0] point_b_y;
    logic                         last;

    modport source (output valid, opcode, point_a_x, point_a_y, point_b_x, point_b_y, last,
                    input ready);
    modport sink   (input valid, opcode, point_a_x, point_a_y, point_b_x, point_b_y, last,
                    output ready);
endinterface

interface rnwh_result_if import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;

    modport source (output valid, hit, hit_x, hit_y, input ready);
    modport sink   (input valid, hit, hit_x, hit_y, output ready);
endinterface

interface rnwh_cfg_if import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
    localparam int unsigned DATA_BITS = cfg_data_bits(COORD_BITS);

    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [DATA_BITS-1:0]     wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

### rtl/rnwh_isect.sv
// Intersection front end: cross products, sign normalisation, range test.
// Four-stage pipeline. Depends on rnwh_pkg.
`default_nettype none

module rnwh_isect import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic signed [COORD_BITS:0]      i_dx,
    input  wire logic signed [COORD_BITS:0]      i_dy,
    input  wire logic signed [COORD_BITS:0]      i_wx,
    input  wire logic signed [COORD_BITS:0]      i_wy,
    input  wire logic signed [COORD_BITS:0]      i_sx,
    input  wire logic signed [COORD_BITS:0]      i_sy,
    output t_isect_stat                          o_stat,
    output logic        [2*COORD_BITS:0]         o_num,
    output logic        [2*COORD_BITS:0]         o_den
);

    localparam int unsigned DIFW = COORD_BITS + 1;
    localparam int unsigned MW   = 2 * DIFW;
    localparam int unsigned PW   = 2 * COORD_BITS + 1;
    localparam int unsigned SW   = PW + 1;
    localparam int unsigned DW   = PW;

    logic signed [2*DIFW-1:0] w_wydx, w_wxdy, w_wxsy, w_wysx, w_dxsy, w_dysx;

    logic        [3:0]    r_vld;
    logic signed [PW-1:0] r_wydx, r_wxdy, r_wxsy, r_wysx, r_dxsy, r_dysx;
    logic signed [SW-1:0] r_den1, r_na1, r_nb1;
    logic signed [SW-1:0] r_den2, r_na2, r_nb2;
    logic                 r_pass;
    logic        [DW-1:0] r_num, r_den;

    assign w_wydx = MW'(i_wy) * MW'(i_dx);
    assign w_wxdy = MW'(i_wx) * MW'(i_dy);
    assign w_wxsy = MW'(i_wx) * MW'(i_sy);
    assign w_wysx = MW'(i_wy) * MW'(i_sx);
    assign w_dxsy = MW'(i_dx) * MW'(i_sy);
    assign w_dysx = MW'(i_dy) * MW'(i_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        // products stay below 2^(2*COORD_BITS) in magnitude
        r_wydx <= w_wydx[PW-1:0];
        r_wxdy <= w_wxdy[PW-1:0];
        r_wxsy <= w_wxsy[PW-1:0];
        r_wysx <= w_wysx[PW-1:0];
        r_dxsy <= w_dxsy[PW-1:0];
        r_dysx <= w_dysx[PW-1:0];

        r_den1 <= SW'(r_wydx) - SW'(r_wxdy);
        r_na1  <= SW'(r_wxsy) - SW'(r_wysx);
        r_nb1  <= SW'(r_dxsy) - SW'(r_dysx);

        if (r_den1[SW-1]) begin
            r_den2 <= -r_den1;
            r_na2  <= -r_na1;
            r_nb2  <= -r_nb1;
        end else begin
            r_den2 <= r_den1;
            r_na2  <= r_na1;
            r_nb2  <= r_nb1;
        end

        r_pass <= (r_den2 != '0) && !r_na2[SW-1] && (r_na2 <= r_den2)
                  && !r_nb2[SW-1] && (r_nb2 <= r_den2);
        r_num  <= r_na2[DW-1:0];
        r_den  <= r_den2[DW-1:0];
    end

    assign o_stat = '{done: r_vld[3], pass: r_pass};
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

`default_nettype wire

### rtl/rnwh_lerp.sv
// Bit-serial interpolation: base +/- trunc(num*|delta|/den).
// Shift-add multiply then restoring divide, one bit a cycle. Depends on rnwh_pkg.
`default_nettype none

module rnwh_lerp import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic        [2*COORD_BITS:0]  i_num,
    input  wire logic        [2*COORD_BITS:0]  i_den,
    input  wire logic signed [COORD_BITS:0]    i_delta,
    input  wire logic signed [COORD_BITS-1:0]  i_base,
    output logic                               o_done,
    output logic signed [COORD_BITS-1:0]       o_point
);

    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned DW   = 2 * CB + 1;
    localparam int unsigned SBW  = CB + 2;
    localparam int unsigned CNTW = $clog2(CB);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIX  = 2'd3;

    logic [1:0]            r_state;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_done;
    logic [DW-1:0]         r_num, r_den, r_acc;
    logic [CB-1:0]         r_mag, r_lo, r_q;
    logic                  r_neg;
    logic signed [CB-1:0]  r_base, r_point;

    logic        [CB:0]    w_abs;
    logic        [DW:0]    w_sum;
    logic        [DW:0]    w_trial;
    logic        [DW+1:0]  w_diff;
    logic                  w_ge;
    logic signed [SBW-1:0] w_qs, w_bs, w_b, w_fix;
    logic                  w_rnz;

    assign w_abs   = i_delta[CB] ? -i_delta : i_delta;
    assign w_sum   = {1'b0, r_acc} + (r_mag[0] ? {1'b0, r_num} : '0);
    assign w_trial = {r_acc, r_lo[CB-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = !w_diff[DW+1];

    assign w_qs  = {2'b00, r_q};
    assign w_bs  = SBW'(r_base);
    assign w_b   = r_neg ? w_bs - w_qs : w_bs + w_qs;
    assign w_rnz = |r_acc;

    // truncate toward zero when the quotient is inexact
    always_comb begin
        w_fix = w_b;
        if (w_rnz && !r_neg && w_b[SBW-1]) begin
            w_fix = w_b + SBW'(1);
        end else if (w_rnz && r_neg && !w_b[SBW-1] && (w_b != '0)) begin
            w_fix = w_b - SBW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= L_DIV;
                    end
                end
                L_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= L_FIX;
                    end
                end
                L_FIX: begin
                    r_state <= L_IDLE;
                    r_done  <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_mag  <= w_abs[CB-1:0];
                r_neg  <= i_delta[CB];
                r_base <= i_base;
                r_acc  <= '0;
                r_cnt  <= CNTW'(CB - 1);
            end
            L_MUL: begin
                r_acc <= w_sum[DW:1];
                r_lo  <= {w_sum[0], r_lo[CB-1:1]};
                r_mag <= r_mag >> 1;
                r_cnt <= (r_cnt == '0) ? CNTW'(CB - 1) : r_cnt - 1'b1;
            end
            L_DIV: begin
                r_acc <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
                r_lo  <= r_lo << 1;
                r_q   <= {r_q[CB-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            L_FIX: begin
                r_point <= w_fix[CB-1:0];
            end
        endcase
    end

    assign o_done  = r_done;
    assign o_point = r_point;

endmodule

`default_nettype wire

### rtl/ray_nearest_wall_hit.sv
// Top level: nearest wall hit along a ray, registers, sequencer, result register.
// Depends on rnwh_pkg, rnwh_if, rnwh_isect, rnwh_lerp, ray_nearest_wall_hit_assert.svh.
//
//  channel   dir  handshake     beat
//  i_item    in   valid/ready   opcode, point_a_x/y, point_b_x/y, last
//  o_result  out  valid/ready   hit, hit_x, hit_y
//  i_cfg     in   valid/ready   addr, wdata (origin_x, origin_y, radius)
//
// A wall beat that passes the range test runs the bit-serial multiply and divide in the
// interpolation units before the next beat is taken; one that fails skips them. A last
// beat also loads the result register.
// Synchronous active-low reset; no clearing pass. i_cfg is always ready.
// A stalled result holds in the result register while further beats are taken.
`default_nettype none
`include "ray_nearest_wall_hit_assert.svh"

module ray_nearest_wall_hit import rnwh_pkg::*; #(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    rnwh_item_if.sink      i_item,
    rnwh_result_if.source  o_result,
    rnwh_cfg_if.sink       i_cfg
);

    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned DIFW = CB + 1;
    localparam int unsigned SQW  = 2 * DIFW;
    localparam int unsigned DW   = 2 * CB + 1;
    localparam int unsigned DSW  = 2 * CB + 1;
    localparam int unsigned RSQW = 2 * RADIUS_BITS;
    localparam int unsigned CMPW = (DSW > RSQW) ? DSW : RSQW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ISECT = 3'd1;
    localparam logic [2:0] S_LERP  = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]              r_state, n_state;
    logic signed [CB-1:0]    r_org_x, r_org_y, r_end_x, r_end_y;
    logic [RADIUS_BITS-1:0]  r_radius;
    logic                    r_isect_go, r_last;
    logic signed [DIFW-1:0]  r_dx, r_dy, r_wx, r_wy, r_sx, r_sy;
    logic signed [DIFW-1:0]  r_ex, r_ey;
    logic [2*CB-1:0]         r_sqx, r_sqy;
    logic [RSQW-1:0]         r_rsq;
    logic [DSW-1:0]          r_dsq, r_best_dsq;
    logic                    r_best_valid;
    logic signed [CB-1:0]    r_best_x, r_best_y;
    logic                    r_out_valid, r_out_hit;
    logic signed [CB-1:0]    r_out_x, r_out_y;

    logic                    w_item_acc, w_cfg_wr, w_out_free, w_emit, w_clear_best, w_take;
    logic                    w_in_radius, w_lerp_go, w_done_x, w_done_y;
    t_isect_stat             w_stat;
    logic [DW-1:0]           w_num, w_den;
    logic signed [CB-1:0]    w_hx, w_hy;
    logic signed [2*DIFW-1:0] w_sqx, w_sqy;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_item_acc   = i_item.valid && i_item.ready;
    assign w_cfg_wr     = i_cfg.valid && i_cfg.ready;

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_emit       = (r_state == S_FIN) && w_out_free;
    assign w_clear_best = (w_item_acc && (i_item.opcode == OP_RAY)) || w_emit;
    assign w_in_radius  = CMPW'(r_dsq) <= CMPW'(r_rsq);
    assign w_take       = (r_state == S_UPD) && w_in_radius
                          && (!r_best_valid || (r_dsq < r_best_dsq));
    assign w_lerp_go    = (r_state == S_ISECT) && w_stat.done && w_stat.pass;

    assign w_sqx = SQW'(r_ex) * SQW'(r_ex);
    assign w_sqy = SQW'(r_ey) * SQW'(r_ey);

    rnwh_isect #(.COORD_BITS(COORD_BITS)) u_isect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_isect_go),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_wx    (r_wx),
        .i_wy    (r_wy),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .o_stat  (w_stat),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    rnwh_lerp #(.COORD_BITS(COORD_BITS)) u_lerp_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_delta (r_dx),
        .i_base  (r_org_x),
        .o_done  (w_done_x),
        .o_point (w_hx)
    );

    rnwh_lerp #(.COORD_BITS(COORD_BITS)) u_lerp_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_go),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_delta (r_dy),
        .i_base  (r_org_y),
        .o_done  (w_done_y),
        .o_point (w_hy)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_item_acc) begin
                    if (i_item.opcode == OP_RAY) begin
                        n_state = i_item.last ? S_FIN : S_IDLE;
                    end else begin
                        n_state = S_ISECT;
                    end
                end
            end
            S_ISECT: begin
                if (w_stat.done) begin
                    if (w_stat.pass) begin
                        n_state = S_LERP;
                    end else begin
                        n_state = r_last ? S_FIN : S_IDLE;
                    end
                end
            end
            S_LERP: begin
                if (w_done_x) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:  n_state = S_SUM;
            S_SUM: n_state = S_UPD;
            S_UPD: n_state = r_last ? S_FIN : S_IDLE;
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_radius <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.addr)
                CFG_ORIGIN_X: r_org_x  <= i_cfg.wdata[CB-1:0];
                CFG_ORIGIN_Y: r_org_y  <= i_cfg.wdata[CB-1:0];
                CFG_RADIUS:   r_radius <= i_cfg.wdata[RADIUS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_isect_go   <= 1'b0;
            r_end_x      <= '0;
            r_end_y      <= '0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_isect_go <= w_item_acc && (i_item.opcode == OP_WALL);
            if (w_item_acc && (i_item.opcode == OP_RAY)) begin
                r_end_x <= i_item.point_a_x;
                r_end_y <= i_item.point_a_y;
            end
            if (w_clear_best) begin
                r_best_valid <= 1'b0;
            end else if (w_take) begin
                r_best_valid <= 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_item_acc) begin
            r_last <= i_item.last;
            r_dx   <= DIFW'(r_end_x) - DIFW'(r_org_x);
            r_dy   <= DIFW'(r_end_y) - DIFW'(r_org_y);
            r_wx   <= DIFW'(i_item.point_b_x) - DIFW'(i_item.point_a_x);
            r_wy   <= DIFW'(i_item.point_b_y) - DIFW'(i_item.point_a_y);
            r_sx   <= DIFW'(r_org_x) - DIFW'(i_item.point_a_x);
            r_sy   <= DIFW'(r_org_y) - DIFW'(i_item.point_a_y);
        end
        if (w_done_x) begin
            r_ex <= DIFW'(w_hx) - DIFW'(r_org_x);
            r_ey <= DIFW'(w_hy) - DIFW'(r_org_y);
        end
        if (r_state == S_SQ) begin
            r_sqx <= w_sqx[2*CB-1:0];
            r_sqy <= w_sqy[2*CB-1:0];
            r_rsq <= RSQW'(r_radius) * RSQW'(r_radius);
        end
        if (r_state == S_SUM) begin
            r_dsq <= DSW'(r_sqx) + DSW'(r_sqy);
        end
        if (w_take) begin
            r_best_x   <= w_hx;
            r_best_y   <= w_hy;
            r_best_dsq <= r_dsq;
        end
        if (w_emit) begin
            r_out_hit <= r_best_valid;
            r_out_x   <= r_best_valid ? r_best_x : '0;
            r_out_y   <= r_best_valid ? r_best_y : '0;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.hit   = r_out_hit;
    assign o_result.hit_x = r_out_x;
    assign o_result.hit_y = r_out_y;

    // both interpolation units run in lockstep
    `RNWH_ASSERT(a_lerp_lockstep, i_clk, i_rst_n, w_done_x == w_done_y)
    // a result beat is only loaded from the final state
    `RNWH_ASSERT_IMPL(a_out_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN)
    // front end only reports while the sequencer waits on it
    `RNWH_ASSERT_IMPL(a_isect_wait, i_clk, i_rst_n, w_stat.done, r_state == S_ISECT)

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking bench for ray_nearest_wall_hit: drives ray and wall beats, writes
// the origin and radius registers, and checks every result against a predictor.
// Depends on rnwh_pkg, rnwh_if and the RTL of the block.
`timescale 1ns / 100ps

import rnwh_pkg::*;

localparam int CB = COORD_BITS_DEF;

typedef struct packed {
    logic                 op;
    logic signed [CB-1:0] ax;
    logic signed [CB-1:0] ay;
    logic signed [CB-1:0] bx;
    logic signed [CB-1:0] by;
    logic                 last;
} t_wall_beat;

typedef struct packed {
    logic                 hit;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
} t_hit_beat;

class nearest_hit_tracker;
    longint org_x, org_y, rad;
    longint end_x, end_y;
    bit     best_ok;
    longint best_x, best_y, best_dsq;
    t_hit_beat hits_due[$];
    int errors;

    function new();
        org_x = 0;
        org_y = 0;
        rad = 0;
        end_x = 0;
        end_y = 0;
        errors = 0;
        drop_best();
    endfunction

    function void drop_best();
        best_ok = 0;
        best_x = 0;
        best_y = 0;
        best_dsq = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [15:0] d);
        case (idx)
            CFG_ORIGIN_X: org_x = $signed(d[CB-1:0]);
            CFG_ORIGIN_Y: org_y = $signed(d[CB-1:0]);
            CFG_RADIUS:   rad = d;
            default: ;
        endcase
    endfunction

    // base + num*delta/den, exact, truncated toward zero
    function longint lerp_toward_zero(longint base, longint delta, longint num, longint den);
        longint unsigned mag, prod, q, r;
        longint b;
        mag = (delta < 0) ? -delta : delta;
        prod = longint'(num) * mag;
        q = prod / longint'(den);
        r = prod % longint'(den);
        if (delta >= 0) begin
            b = base + longint'(q);
            if (r != 0 && b < 0) b = b + 1;
        end else begin
            b = base - longint'(q);
            if (r != 0 && b > 0) b = b - 1;
        end
        return b;
    endfunction

    function void try_wall(longint x3, longint y3, longint x4, longint y4);
        longint dx, dy, wx, wy, den, na, nb, hx, hy, ex, ey, dsq;
        dx = end_x - org_x;
        dy = end_y - org_y;
        wx = x4 - x3;
        wy = y4 - y3;
        den = wy * dx - wx * dy;
        na = wx * (org_y - y3) - wy * (org_x - x3);
        nb = dx * (org_y - y3) - dy * (org_x - x3);
        if (den == 0) return;
        if (den < 0) begin
            den = -den;
            na = -na;
            nb = -nb;
        end
        if (na < 0 || na > den || nb < 0 || nb > den) return;
        hx = lerp_toward_zero(org_x, dx, na, den);
        hy = lerp_toward_zero(org_y, dy, na, den);
        ex = hx - org_x;
        ey = hy - org_y;
        dsq = ex * ex + ey * ey;
        if (dsq > rad * rad) return;
        if (!best_ok || dsq < best_dsq) begin
            best_ok = 1;
            best_x = hx;
            best_y = hy;
            best_dsq = dsq;
        end
    endfunction

    function void note_beat(t_wall_beat b);
        t_hit_beat h;
        if (b.op == OP_RAY) begin
            end_x = b.ax;
            end_y = b.ay;
            drop_best();
        end else begin
            try_wall(b.ax, b.ay, b.bx, b.by);
        end
        if (b.last) begin
            h.hit = best_ok;
            h.x = best_ok ? best_x[CB-1:0] : '0;
            h.y = best_ok ? best_y[CB-1:0] : '0;
            hits_due.insert(hits_due.size(), h);
            drop_best();
        end
    endfunction

    function void check_hit(t_hit_beat got);
        t_hit_beat want;
        if (hits_due.size() == 0) begin
            $display("%0t: unexpected result beat: hit %0b x %0d y %0d",
                     $time, got.hit, got.x, got.y);
            errors++;
            return;
        end
        want = hits_due.pop_front();
        if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, got.hit);
            errors++;
        end
        if (got.x !== want.x) begin
            $display("%0t: hit_x expected %0d, got %0d", $time, want.x, got.x);
            errors++;
        end
        if (got.y !== want.y) begin
            $display("%0t: hit_y expected %0d, got %0d", $time, want.y, got.y);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE      = 60;
    localparam int HOLD_CYCLES = 600;
    localparam int PHASE_BEATS = 85;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rnwh_item_if   #(.COORD_BITS(CB)) item_ch ();
    rnwh_result_if #(.COORD_BITS(CB)) result_ch ();
    rnwh_cfg_if    #(.COORD_BITS(CB)) cfg_ch ();

    ray_nearest_wall_hit #(.COORD_BITS(CB)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    nearest_hit_tracker hits = new();
    bit send_calm;
    bit take_calm;
    bit hold_results;
    int sent_in_phase;

    always #4 i_clk = ~i_clk;

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        longint hi;
        hi = (longint'(1) <<< (CB - 1)) - 1;
        if (v > hi) return hi[CB-1:0];
        if (v < -hi - 1) return ~hi[CB-1:0];
        return v[CB-1:0];
    endfunction

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_wall_beat mk(logic op, int ax, int ay, int bx, int by, logic last);
        t_wall_beat b;
        b.op = op;
        b.ax = ax[CB-1:0];
        b.ay = ay[CB-1:0];
        b.bx = bx[CB-1:0];
        b.by = by[CB-1:0];
        b.last = last;
        return b;
    endfunction

    function automatic t_wall_beat stray_beat();
        t_wall_beat b;
        b.op = 1'($urandom_range(0, 1));
        b.ax = CB'($urandom());
        b.ay = CB'($urandom());
        b.bx = CB'($urandom());
        b.by = CB'($urandom());
        b.last = ($urandom_range(0, 2) == 0);
        return b;
    endfunction

    task automatic send_beat(t_wall_beat b);
        int gap;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.opcode    <= b.op;
        item_ch.point_a_x <= b.ax;
        item_ch.point_a_y <= b.ay;
        item_ch.point_b_x <= b.bx;
        item_ch.point_b_y <= b.by;
        item_ch.last      <= b.last;
        item_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        hits.note_beat(b);
        sent_in_phase++;
    endtask

    task automatic set_regs(int ox, int oy, int r);
        logic [CFG_ADDR_BITS-1:0] idx [3];
        logic [15:0] val [3];
        idx[0] = CFG_ORIGIN_X;
        idx[1] = CFG_ORIGIN_Y;
        idx[2] = CFG_RADIUS;
        val[0] = ox[15:0];
        val[1] = oy[15:0];
        val[2] = r[15:0];
        for (int i = 0; i < 3; i++) begin
            cfg_ch.addr  <= idx[i];
            cfg_ch.wdata <= val[i];
            cfg_ch.valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ch.ready);
            hits.write_reg(idx[i], val[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // all results in, then room for a wall beat still in the divider
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (hits.hits_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // begin beat, then walls mostly laid across the ray so that they hit
    task automatic ray_session(int span, bit full);
        t_wall_beat b;
        int n, k, s, u, v;
        longint ex, ey, px, py;
        n = $urandom_range(1, 6);
        ex = full ? longint'($signed(16'($urandom()))) : hits.org_x + near(span);
        ey = full ? longint'($signed(16'($urandom()))) : hits.org_y + near(span);
        b.op = OP_RAY;
        b.ax = clamp_coord(ex);
        b.ay = clamp_coord(ey);
        b.bx = CB'($urandom());
        b.by = CB'($urandom());
        b.last = ($urandom_range(0, 9) == 0);
        ex = b.ax;
        ey = b.ay;
        send_beat(b);
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 8);
            px = hits.org_x + (ex - hits.org_x) * k / 8;
            py = hits.org_y + (ey - hits.org_y) * k / 8;
            if ($urandom_range(0, 5) == 0) begin
                px = hits.org_x + near(span);
                py = hits.org_y + near(span);
            end
            u = near(span / 4 + 1);
            v = near(span / 4 + 1);
            s = $urandom_range(1, 3);
            b.op = OP_WALL;
            b.ax = clamp_coord(px + u);
            b.ay = clamp_coord(py + v);
            b.bx = clamp_coord(px - longint'(u) * s);
            b.by = clamp_coord(py - longint'(v) * s);
            b.last = (i == n - 1);
            send_beat(b);
        end
    endtask

    task automatic run_phase(int ox, int oy, int r, int span, bit full);
        set_regs(ox, oy, r);
        sent_in_phase = 0;
        while (sent_in_phase < PHASE_BEATS) begin
            if ($urandom_range(0, 4) == 0) send_beat(stray_beat());
            else ray_session(span, full);
        end
        drain();
    endtask

    initial begin : result_side
        int gap;
        t_hit_beat got;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
            gap = take_calm ? 0 : $urandom_range(0, 9);
            if (hold_results) begin
                gap = HOLD_CYCLES;
                hold_results = 0;
            end
            if (gap > 0) begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
            got.hit = result_ch.hit;
            got.x = result_ch.hit_x;
            got.y = result_ch.hit_y;
            hits.check_hit(got);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_ch.valid && item_ch.ready)
                    || (result_ch.valid && result_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.opcode    <= OP_RAY;
        item_ch.point_a_x <= '0;
        item_ch.point_a_y <= '0;
        item_ch.point_b_x <= '0;
        item_ch.point_b_y <= '0;
        item_ch.last      <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.addr       <= CFG_ORIGIN_X;
        cfg_ch.wdata      <= '0;
        send_calm = 0;
        take_calm = 0;
        hold_results = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: wall before any ray, then a lone begin beat
        send_beat(mk(OP_WALL, -5, -5, 5, 5, 1));
        send_beat(mk(OP_RAY, 100, 0, 32767, -32768, 1));
        drain();

        set_regs(0, 0, 1000);
        send_beat(mk(OP_RAY, 100, 0, -32768, 32767, 0));
        send_beat(mk(OP_WALL, 50, -10, 50, 10, 0));
        send_beat(mk(OP_WALL, 30, -5, 30, 5, 0));
        send_beat(mk(OP_WALL, 30, 5, 30, -5, 0));
        send_beat(mk(OP_WALL, 0, 5, 100, 5, 0));
        send_beat(mk(OP_WALL, 20, 0, 20, 0, 0));
        send_beat(mk(OP_WALL, 100, -1, 100, 1, 0));
        send_beat(mk(OP_WALL, 10, 0, 10, 20, 1));
        // same ray again, no begin beat
        send_beat(mk(OP_WALL, 60, -3, 60, 3, 1));
        // negative direction, fractional hit points
        send_beat(mk(OP_RAY, -7, -3, 0, 0, 0));
        send_beat(mk(OP_WALL, -5, -10, -5, 10, 0));
        send_beat(mk(OP_WALL, 0, -1, -10, -1, 1));
        // wall beyond the ray end
        send_beat(mk(OP_RAY, 3, 0, 0, 0, 0));
        send_beat(mk(OP_WALL, 10, -1, 10, 1, 1));
        // zero-length ray
        send_beat(mk(OP_RAY, 0, 0, 0, 0, 0));
        send_beat(mk(OP_WALL, -1, -1, 1, 1, 1));
        drain();

        set_regs(-32768, -32768, 65535);
        send_beat(mk(OP_RAY, 32767, 32767, 0, 0, 0));
        send_beat(mk(OP_WALL, 32767, 32000, 32000, 32767, 0));
        send_beat(mk(OP_WALL, 32767, -32768, -32768, 32767, 1));
        send_beat(mk(OP_RAY, -32768, -32768, 32767, 32767, 0));
        send_beat(mk(OP_WALL, 32767, -32768, -32768, 32767, 1));
        drain();

        run_phase(0, 0, 65535, 1000, 0);
        run_phase(-32768, 32767, 65535, 32767, 1);
        run_phase(near(500), near(500), 0, 400, 0);
        run_phase(near(2000), near(2000), $urandom_range(50, 3000), 2000, 0);
        run_phase(32767, -32768, $urandom_range(0, 65535), 32767, 1);
        hold_results = 1;
        run_phase(0, 0, 300, 200, 0);
        run_phase(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))),
                  $urandom_range(0, 65535), 32767, 1);
        run_phase(0, 0, 65535, 30, 0);

        if (hits.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
